// ----- rtl/der_tbs_certificate_checker_unit_defines.svh -----
// ----------------------------------------------------------------------------
// DER TBS checker assertion macros
// Shared assertion helpers; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef DER_TBS_CERTIFICATE_CHECKER_UNIT_DEFINES_SVH
`define DER_TBS_CERTIFICATE_CHECKER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define DTC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DTC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define DTC_ASSERT(label, clk, rst_n, prop, msg)
`define DTC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- rtl/dtc_pkg.sv -----
// ----------------------------------------------------------------------------
// DER TBS checker package
// Schema step codes, tables and result types.
// ----------------------------------------------------------------------------
package dtc_pkg;
  localparam int LENGTH_BITS = 32;
  localparam int MAX_DIGITS = LENGTH_BITS / 8;
  localparam int DIG_W = $clog2(MAX_DIGITS + 1);

  typedef logic [LENGTH_BITS-1:0] len_t;

  typedef enum logic [1:0] {PH_TAG, PH_LEN, PH_DIG, PH_BODY} phase_t;
  typedef enum logic [1:0] {K_OPAQUE, K_INT, K_BITS, K_BOX} kind_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] E_LEN   = 2'd2;
  localparam logic [1:0] E_FMT   = 2'd3;

  localparam logic [3:0] CLS_NONE = 4'd11;

  typedef enum logic [3:0] {
    S_OUTER, S_VER, S_VINT, S_SERIAL, S_SIGALG, S_ISSUER, S_VALIDITY,
    S_SUBJECT, S_SPKI, S_KEYALG, S_KEYBITS, S_T81, S_T82, S_TA3, S_EXTSEQ
  } step_t;

  localparam logic [7:0] TAG_INT  = 8'h02;
  localparam logic [7:0] TAG_BITS = 8'h03;
  localparam logic [7:0] TAG_SEQ  = 8'h30;
  localparam logic [7:0] TAG_81   = 8'h81;
  localparam logic [7:0] TAG_82   = 8'h82;
  localparam logic [7:0] TAG_A0   = 8'ha0;
  localparam logic [7:0] TAG_A3   = 8'ha3;

  typedef struct packed {
    logic [3:0] field_class;
    logic       field_end;
    logic [1:0] status;
  } result_t;

  function automatic logic [7:0] step_tag(step_t s);
    case (s)
      S_VER:                 step_tag = TAG_A0;
      S_VINT, S_SERIAL:      step_tag = TAG_INT;
      S_KEYBITS:             step_tag = TAG_BITS;
      S_T81:                 step_tag = TAG_81;
      S_T82:                 step_tag = TAG_82;
      S_TA3:                 step_tag = TAG_A3;
      default:               step_tag = TAG_SEQ;
    endcase
  endfunction

  function automatic logic [1:0] step_level(step_t s);
    case (s)
      S_OUTER:                                step_level = 2'd0;
      S_VINT, S_KEYALG, S_KEYBITS, S_EXTSEQ:  step_level = 2'd2;
      default:                                step_level = 2'd1;
    endcase
  endfunction

  function automatic logic [3:0] step_class(step_t s);
    case (s)
      S_OUTER:          step_class = 4'd0;
      S_VER, S_VINT:    step_class = 4'd1;
      S_SERIAL:         step_class = 4'd2;
      S_SIGALG:         step_class = 4'd3;
      S_ISSUER:         step_class = 4'd4;
      S_VALIDITY:       step_class = 4'd5;
      S_SUBJECT:        step_class = 4'd6;
      S_SPKI:           step_class = 4'd7;
      S_KEYALG:         step_class = 4'd8;
      S_KEYBITS:        step_class = 4'd9;
      default:          step_class = 4'd10;
    endcase
  endfunction

  function automatic kind_t step_kind(step_t s);
    case (s)
      S_OUTER, S_VER, S_SPKI, S_TA3: step_kind = K_BOX;
      S_VINT, S_SERIAL:              step_kind = K_INT;
      S_KEYBITS, S_T81, S_T82:       step_kind = K_BITS;
      default:                       step_kind = K_OPAQUE;
    endcase
  endfunction
endpackage

// ----- rtl/dtc_core.sv -----
// ----------------------------------------------------------------------------
// DER TBS checker core
// Schema state and one-byte update; registers one result per byte.
// ----------------------------------------------------------------------------
module dtc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output dtc_pkg::result_t  res
);
  import dtc_pkg::*;

  len_t            rr0_r, rr1_r, rr2_r;
  step_t           step_r;
  phase_t          phase_r;
  logic [DIG_W-1:0] dig_r;
  len_t            acc_r;
  logic [7:0]      cfirst_r;
  logic [1:0]      ccount_r;
  logic [1:0]      err_r;

  len_t            rr0_nxt, rr1_nxt, rr2_nxt;
  step_t           step_nxt;
  phase_t          phase_nxt;
  logic [DIG_W-1:0] dig_nxt;
  len_t            acc_nxt;
  logic [7:0]      cfirst_nxt;
  logic [1:0]      ccount_nxt;
  logic [1:0]      err_nxt;
  result_t         res_nxt, res_r;

  always_comb begin
    step_t       s;
    logic [1:0]  lvl;
    len_t        room, left, hlen, acc_w;
    logic        v_done, v_end, hdr_go, el_go, ent_go;
    step_t       child, nxt_s;
    kind_t       kind;
    logic [6:0]  n;
    logic [7:0]  mask;
    logic [1:0]  status;
    logic [3:0]  cls;

    rr0_nxt = rr0_r; rr1_nxt = rr1_r; rr2_nxt = rr2_r;
    step_nxt = step_r; phase_nxt = phase_r; dig_nxt = dig_r; acc_nxt = acc_r;
    cfirst_nxt = cfirst_r; ccount_nxt = ccount_r; err_nxt = err_r;
    v_done = 1'b0; v_end = 1'b0; hdr_go = 1'b0; el_go = 1'b0; ent_go = 1'b0;
    hlen = '0; child = S_EXTSEQ; nxt_s = S_OUTER; room = '0; left = '0;
    n = '0; mask = '0; acc_w = '0; cls = CLS_NONE;
    s = step_r; lvl = '0; kind = K_OPAQUE;

    if (err_r == ST_OK) begin
      if (phase_r == PH_TAG) begin
        if (s == S_VER && data_byte != TAG_A0) s = S_SERIAL;
        else if (s == S_T81 && data_byte == TAG_82) s = S_T82;
        if ((s == S_T81 || s == S_T82) && data_byte == TAG_A3) s = S_TA3;
        step_nxt = s;
      end
      lvl = step_level(s);
      cls = step_class(s);
      kind = step_kind(s);
      if (lvl > 2'd0 && rr0_nxt != '0) rr0_nxt = rr0_nxt - 1'b1;
      if (lvl > 2'd1 && rr1_nxt != '0) rr1_nxt = rr1_nxt - 1'b1;
      if (phase_r == PH_BODY) begin
        case (lvl)
          2'd0: if (rr0_nxt != '0) rr0_nxt = rr0_nxt - 1'b1;
          2'd1: if (rr1_nxt != '0) rr1_nxt = rr1_nxt - 1'b1;
          default: if (rr2_nxt != '0) rr2_nxt = rr2_nxt - 1'b1;
        endcase
      end
      room = (lvl == 2'd2) ? rr1_nxt : rr0_nxt;
      left = (lvl == 2'd0) ? rr0_nxt : (lvl == 2'd1) ? rr1_nxt : rr2_nxt;

      case (phase_r)
        PH_TAG: begin
          if (s >= S_T81 && s <= S_TA3 && data_byte != step_tag(s)) err_nxt = E_FMT;
          else if (lvl > 2'd0 && room == '0) err_nxt = E_LEN;
          else if (data_byte != step_tag(s)) err_nxt = E_FMT;
          else phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          if (!data_byte[7]) begin
            hdr_go = 1'b1;
            hlen = LENGTH_BITS'(data_byte);
          end else begin
            n = data_byte[6:0];
            if (n == '0 || n > 7'(MAX_DIGITS)) err_nxt = E_FMT;
            else if (lvl > 2'd0 && LENGTH_BITS'(n) > room) err_nxt = E_LEN;
            else begin
              dig_nxt = DIG_W'(n);
              acc_nxt = '0;
              phase_nxt = PH_DIG;
            end
          end
        end
        PH_DIG: begin
          if (acc_r == '0 && data_byte == 8'h00) err_nxt = E_FMT;
          else begin
            acc_w = {acc_r[LENGTH_BITS-9:0], data_byte};
            acc_nxt = acc_w;
            if (dig_r > '0) dig_nxt = dig_r - 1'b1;
            if (dig_nxt == '0) begin
              if (acc_w < LENGTH_BITS'(128)) err_nxt = E_FMT;
              else if (lvl > 2'd0 && acc_w > room) err_nxt = E_LEN;
              else begin
                hdr_go = 1'b1;
                hlen = acc_w;
              end
            end
          end
        end
        default: begin
          if (ccount_r == 2'd0) cfirst_nxt = data_byte;
          if (kind == K_INT && ccount_r == 2'd1 &&
              ((cfirst_r == 8'h00 && !data_byte[7]) ||
               (cfirst_r == 8'hff && data_byte[7]))) err_nxt = E_FMT;
          else if (kind == K_BITS && ccount_r == 2'd0 &&
                   (data_byte > 8'd7 || (left == '0 && data_byte != 8'h00)))
            err_nxt = E_FMT;
          else begin
            mask = (8'd1 << cfirst_nxt[2:0]) - 8'd1;
            if (kind == K_BITS && left == '0 && cfirst_nxt != 8'h00 &&
                (data_byte & mask) != 8'h00) err_nxt = E_FMT;
            else begin
              if (ccount_r < 2'd2) ccount_nxt = ccount_r + 2'd1;
              if (left == '0) el_go = 1'b1;
            end
          end
        end
      endcase

      if (hdr_go) begin
        case (lvl)
          2'd0: rr0_nxt = hlen;
          2'd1: rr1_nxt = hlen;
          default: rr2_nxt = hlen;
        endcase
        ccount_nxt = 2'd0;
        if (kind == K_BOX) begin
          if (s == S_OUTER || s == S_SPKI) v_end = 1'b1;
          if (s == S_OUTER) child = S_VER;
          else if (s == S_VER) child = S_VINT;
          else if (s == S_SPKI) child = S_KEYALG;
          nxt_s = child;
          ent_go = 1'b1;
        end else if (hlen == '0) begin
          if (kind == K_OPAQUE) el_go = 1'b1;
          else err_nxt = E_FMT;
        end else phase_nxt = PH_BODY;
      end

      if (el_go) begin
        v_end = 1'b1;
        if ((s == S_VINT || s == S_KEYBITS || s == S_EXTSEQ) && rr1_nxt != '0)
          err_nxt = E_FMT;
        else begin
          ent_go = 1'b1;
          case (s)
            S_VINT:    nxt_s = S_SERIAL;
            S_SERIAL:  nxt_s = S_SIGALG;
            S_SIGALG:  nxt_s = S_ISSUER;
            S_ISSUER:  nxt_s = S_VALIDITY;
            S_VALIDITY: nxt_s = S_SUBJECT;
            S_SUBJECT: nxt_s = S_SPKI;
            S_KEYALG:  nxt_s = S_KEYBITS;
            S_KEYBITS: nxt_s = S_T81;
            S_T81:     nxt_s = S_T82;
            S_T82:     nxt_s = S_TA3;
            default:   ent_go = 1'b0;
          endcase
          if (s == S_EXTSEQ) begin
            if (rr0_nxt != '0) err_nxt = E_FMT;
            else if (last_byte) v_done = 1'b1;
            else err_nxt = E_FMT;
          end
        end
      end

      if (ent_go) begin
        step_nxt = nxt_s;
        phase_nxt = PH_TAG;
        if (nxt_s == S_T81 || nxt_s == S_T82 || nxt_s == S_TA3) begin
          if (rr0_nxt == '0) begin
            if (last_byte) v_done = 1'b1;
            else if (err_nxt == ST_OK) err_nxt = E_FMT;
          end
        end else if (step_level(nxt_s) == 2'd2) begin
          if (rr1_nxt == '0 && err_nxt == ST_OK) err_nxt = E_LEN;
        end else if (rr0_nxt == '0 && err_nxt == ST_OK) err_nxt = E_LEN;
      end

      if (err_nxt == ST_OK && last_byte && !v_done) err_nxt = E_LEN;
    end

    if (err_nxt != ST_OK) status = err_nxt;
    else if (v_done) status = ST_DONE;
    else status = ST_OK;
    res_nxt.field_class = cls;
    res_nxt.field_end = v_end && !status[1];
    res_nxt.status = status;

    if (last_byte) begin
      rr0_nxt = '0; rr1_nxt = '0; rr2_nxt = '0;
      step_nxt = S_OUTER; phase_nxt = PH_TAG; dig_nxt = '0; acc_nxt = '0;
      cfirst_nxt = '0; ccount_nxt = '0; err_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rr0_r <= '0; rr1_r <= '0; rr2_r <= '0;
      step_r <= S_OUTER; phase_r <= PH_TAG; dig_r <= '0; acc_r <= '0;
      cfirst_r <= '0; ccount_r <= '0; err_r <= ST_OK;
    end else if (step_en) begin
      rr0_r <= rr0_nxt; rr1_r <= rr1_nxt; rr2_r <= rr2_nxt;
      step_r <= step_nxt; phase_r <= phase_nxt; dig_r <= dig_nxt; acc_r <= acc_nxt;
      cfirst_r <= cfirst_nxt; ccount_r <= ccount_nxt; err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) res_r <= res_nxt;
  end

  assign res = res_r;
endmodule

// ----- rtl/der_tbs_certificate_checker_unit.sv -----
// ----------------------------------------------------------------------------
// DER TBS certificate checker
// Byte-serial DER TBSCertificate schema check, one result word per byte.
// ----------------------------------------------------------------------------
// A result word is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless the output stalls; the combinational schema update sets it.
// A full output register stalls input only while it is not taken.
// Reset: synchronous active-low rst_n clears schema state and the output valid.
module der_tbs_certificate_checker_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [3:0] field_class, [4] field_end, [6:5] status
);
  import dtc_pkg::*;
`include "der_tbs_certificate_checker_unit_defines.svh"

  logic    out_valid_r;
  logic    take;
  result_t res;

  assign in_tready = !out_valid_r || out_tready;
  assign take = in_tvalid && in_tready;

  dtc_core u_core (
    .clk(clk), .rst_n(rst_n), .step_en(take),
    .data_byte(in_tdata), .last_byte(in_tlast), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {1'b0, res.status, res.field_end, res.field_class};

  `DTC_ASSERT_NEXT(a_take_valid, clk, rst_n, take, out_tvalid, "accepted byte gave no word")
  `DTC_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata), "held word changed")
  `DTC_ASSERT(a_class, clk, rst_n, out_tvalid |-> out_tdata[3:0] <= CLS_NONE, "bad class")
  `DTC_ASSERT(a_end_ok, clk, rst_n, out_tvalid && out_tdata[4] |-> !out_tdata[6], "end with error")
endmodule

// ----- sim/tb_der_tbs_certificate_checker_unit.sv -----
// ----------------------------------------------------------------------------
// DER TBS certificate checker testbench
// Streams well-formed, corrupted and random TBSCertificate encodings through
// the checker and compares every result word with a local schema tracker.
// ----------------------------------------------------------------------------
module tb_der_tbs_certificate_checker_unit;
  import dtc_pkg::*;

  typedef logic [7:0] bq_t[$];
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;

  der_tbs_certificate_checker_unit i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  in_word_t   pend_q[$];
  logic [7:0] exp_words[$];
  int         errors = 0;
  int         words_in = 0;
  int         words_out = 0;
  int         certs = 0;
  int         send_idle = 0;
  int         rcv_stall = 0;
  logic       hold = 1'b0;

  // schema tracker state
  logic [31:0] rem[4];
  step_t       cur_step;
  phase_t      cur_ph;
  int          dig_left;
  logic [31:0] acc;
  logic [7:0]  c_first;
  int          c_cnt;
  logic [1:0]  err;
  logic        v_last, v_done, v_end;

  function automatic logic [7:0] tag_of(step_t s);
    case (s)
      S_VER:            return TAG_A0;
      S_VINT, S_SERIAL: return TAG_INT;
      S_KEYBITS:        return TAG_BITS;
      S_T81:            return TAG_81;
      S_T82:            return TAG_82;
      S_TA3:            return TAG_A3;
      default:          return TAG_SEQ;
    endcase
  endfunction

  function automatic int lvl_of(step_t s);
    case (s)
      S_OUTER:                               return 0;
      S_VINT, S_KEYALG, S_KEYBITS, S_EXTSEQ: return 2;
      default:                               return 1;
    endcase
  endfunction

  function automatic logic [3:0] cls_of(step_t s);
    case (s)
      S_OUTER:       return 4'd0;
      S_VER, S_VINT: return 4'd1;
      S_SERIAL:      return 4'd2;
      S_SIGALG:      return 4'd3;
      S_ISSUER:      return 4'd4;
      S_VALIDITY:    return 4'd5;
      S_SUBJECT:     return 4'd6;
      S_SPKI:        return 4'd7;
      S_KEYALG:      return 4'd8;
      S_KEYBITS:     return 4'd9;
      default:       return 4'd10;
    endcase
  endfunction

  function automatic kind_t kind_of(step_t s);
    case (s)
      S_OUTER, S_VER, S_SPKI, S_TA3: return K_BOX;
      S_VINT, S_SERIAL:              return K_INT;
      S_KEYBITS, S_T81, S_T82:       return K_BITS;
      default:                       return K_OPAQUE;
    endcase
  endfunction

  function automatic void clear_tracker();
    for (int i = 0; i < 4; i++) rem[i] = '0;
    cur_step = S_OUTER;
    cur_ph = PH_TAG;
    dig_left = 0;
    acc = '0;
    c_first = '0;
    c_cnt = 0;
    err = ST_OK;
  endfunction

  function automatic void raise(logic [1:0] c);
    if (err == ST_OK) err = c;
  endfunction

  function automatic void outer_closed();
    if (v_last) v_done = 1'b1;
    else raise(E_FMT);
  endfunction

  function automatic void go_step(step_t n);
    cur_step = n;
    cur_ph = PH_TAG;
    if (n == S_T81 || n == S_T82 || n == S_TA3) begin
      if (rem[0] == 0) outer_closed();
    end else if (lvl_of(n) == 2) begin
      if (rem[1] == 0) raise(E_LEN);
    end else if (rem[0] == 0) begin
      raise(E_LEN);
    end
  endfunction

  function automatic void elem_closed(step_t s);
    v_end = 1'b1;
    if ((s == S_VINT || s == S_KEYBITS || s == S_EXTSEQ) && rem[1] != 0) begin
      raise(E_FMT);
      return;
    end
    case (s)
      S_VINT:    go_step(S_SERIAL);
      S_SERIAL, S_SIGALG, S_ISSUER, S_VALIDITY, S_SUBJECT:
                 go_step(step_t'(s + 1));
      S_KEYALG:  go_step(S_KEYBITS);
      S_KEYBITS: go_step(S_T81);
      S_T81:     go_step(S_T82);
      S_T82:     go_step(S_TA3);
      S_EXTSEQ: begin
        if (rem[0] != 0) raise(E_FMT);
        else outer_closed();
      end
      default: ;
    endcase
  endfunction

  function automatic void header_closed(step_t s, int lvl, logic [31:0] len);
    step_t child;
    rem[lvl] = len;
    c_cnt = 0;
    if (kind_of(s) == K_BOX) begin
      child = S_EXTSEQ;
      if (s == S_OUTER || s == S_SPKI) v_end = 1'b1;
      if (s == S_OUTER) child = S_VER;
      else if (s == S_VER) child = S_VINT;
      else if (s == S_SPKI) child = S_KEYALG;
      go_step(child);
    end else if (len == 0) begin
      if (kind_of(s) == K_OPAQUE) elem_closed(s);
      else raise(E_FMT);
    end else begin
      cur_ph = PH_BODY;
    end
  endfunction

  function automatic void content_byte(step_t s, int lvl, logic [7:0] b);
    logic [31:0] left;
    logic [7:0]  mask;
    left = rem[lvl];
    if (c_cnt == 0) c_first = b;
    if (kind_of(s) == K_INT && c_cnt == 1) begin
      if ((c_first == 8'h00 && !b[7]) || (c_first == 8'hff && b[7])) begin
        raise(E_FMT);
        return;
      end
    end
    if (kind_of(s) == K_BITS) begin
      if (c_cnt == 0 && (b > 8'd7 || (left == 0 && b != 0))) begin
        raise(E_FMT);
        return;
      end
      mask = (8'd1 << c_first[2:0]) - 8'd1;
      if (left == 0 && c_first != 0 && (b & mask) != 0) begin
        raise(E_FMT);
        return;
      end
    end
    if (c_cnt < 2) c_cnt++;
    if (left == 0) elem_closed(s);
  endfunction

  function automatic logic [7:0] predict_word(logic [7:0] b, logic last);
    step_t       s;
    int          lvl;
    logic [31:0] room;
    logic [3:0]  cls;
    logic [1:0]  st;
    logic [6:0]  n;
    cls = CLS_NONE;
    v_last = last;
    v_done = 1'b0;
    v_end = 1'b0;
    if (err == ST_OK) begin
      s = cur_step;
      room = '0;
      if (cur_ph == PH_TAG) begin
        if (s == S_VER && b != TAG_A0) s = S_SERIAL;
        else if (s == S_T81 && b == TAG_82) s = S_T82;
        if ((s == S_T81 || s == S_T82) && b == TAG_A3) s = S_TA3;
        cur_step = s;
      end
      lvl = lvl_of(s);
      cls = cls_of(s);
      for (int i = 0; i < lvl; i++) if (rem[i] != 0) rem[i]--;
      if (cur_ph == PH_BODY && rem[lvl] != 0) rem[lvl]--;
      if (lvl > 0) room = rem[lvl-1];
      case (cur_ph)
        PH_TAG: begin
          if (s >= S_T81 && s <= S_TA3 && b != tag_of(s)) raise(E_FMT);
          else if (lvl > 0 && room == 0) raise(E_LEN);
          else if (b != tag_of(s)) raise(E_FMT);
          else cur_ph = PH_LEN;
        end
        PH_LEN: begin
          if (!b[7]) begin
            header_closed(s, lvl, {24'd0, b});
          end else begin
            n = b[6:0];
            if (n == 0 || n > MAX_DIGITS) raise(E_FMT);
            else if (lvl > 0 && n > room) raise(E_LEN);
            else begin
              dig_left = n;
              acc = '0;
              cur_ph = PH_DIG;
            end
          end
        end
        PH_DIG: begin
          if (acc == 0 && b == 0) begin
            raise(E_FMT);
          end else begin
            acc = (acc << 8) | b;
            if (dig_left > 0) dig_left--;
            if (dig_left == 0) begin
              if (acc < 128) raise(E_FMT);
              else if (lvl > 0 && acc > room) raise(E_LEN);
              else header_closed(s, lvl, acc);
            end
          end
        end
        default: content_byte(s, lvl, b);
      endcase
      if (err == ST_OK && v_last && !v_done) raise(E_LEN);
    end
    if (err != ST_OK) st = err;
    else if (v_done) st = ST_DONE;
    else st = ST_OK;
    predict_word = {1'b0, st, v_end && st < E_LEN, cls};
    if (last) clear_tracker();
  endfunction

  // encoding generators
  function automatic bq_t rand_bytes(int n);
    bq_t r;
    for (int i = 0; i < n; i++) r.push_back(8'($urandom));
    return r;
  endfunction

  function automatic bq_t tlv(logic [7:0] tag, bq_t body);
    bq_t r;
    int  n;
    n = body.size();
    r.push_back(tag);
    if (n < 128) r.push_back(8'(n));
    else if (n < 256) begin
      r.push_back(8'h81);
      r.push_back(8'(n));
    end else begin
      r.push_back(8'h82);
      r.push_back(8'(n >> 8));
      r.push_back(8'(n));
    end
    return {r, body};
  endfunction

  function automatic bq_t min_int();
    bq_t r;
    r = rand_bytes($urandom_range(1, 3));
    if (r.size() > 1 && r[0] == 8'h00) r[1][7] = 1'b1;
    if (r.size() > 1 && r[0] == 8'hff) r[1][7] = 1'b0;
    return r;
  endfunction

  function automatic bq_t bit_str();
    bq_t        r;
    logic [7:0] u;
    int         n;
    n = $urandom_range(0, 3);
    u = (n == 0) ? 8'd0 : 8'($urandom_range(0, 7));
    r.push_back(u);
    r = {r, rand_bytes(n)};
    if (n > 0) r[n] = r[n] & ~((8'd1 << u[2:0]) - 8'd1);
    return tlv(TAG_BITS, r);
  endfunction

  function automatic bq_t opaque_seq();
    int n;
    n = $urandom_range(0, 5);
    if ($urandom_range(0, 39) == 0) n = 130 + $urandom_range(0, 100);
    else if ($urandom_range(0, 79) == 0) n = 260 + $urandom_range(0, 20);
    return tlv(TAG_SEQ, rand_bytes(n));
  endfunction

  function automatic bq_t make_cert();
    bq_t b;
    bq_t t;
    if ($urandom_range(0, 1)) b = tlv(TAG_A0, tlv(TAG_INT, min_int()));
    b = {b, tlv(TAG_INT, min_int())};
    for (int i = 0; i < 4; i++) b = {b, opaque_seq()};
    b = {b, tlv(TAG_SEQ, {tlv(TAG_SEQ, rand_bytes($urandom_range(0, 4))), bit_str()})};
    if ($urandom_range(0, 1)) begin
      t = bit_str();
      b = {b, tlv(TAG_81, t[2:$])};
    end
    if ($urandom_range(0, 1)) begin
      t = bit_str();
      b = {b, tlv(TAG_82, t[2:$])};
    end
    if ($urandom_range(0, 1)) b = {b, tlv(TAG_A3, opaque_seq())};
    return tlv(TAG_SEQ, b);
  endfunction

  task automatic queue_run(bq_t b);
    in_word_t w;
    foreach (b[i]) begin
      w.data = b[i];
      w.last = (i == b.size() - 1);
      pend_q.push_back(w);
    end
    certs++;
  endtask

  task automatic queue_random(int nbytes);
    bq_t b;
    int  k;
    int  target;
    target = words_in + pend_q.size() + nbytes;
    while (words_in + pend_q.size() < target) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_run(rand_bytes($urandom_range(1, 6)));
      end else begin
        b = make_cert();
        case ($urandom_range(0, 7))
          0: b[$urandom_range(0, b.size() - 1)] = 8'($urandom);
          1: b = b[0:$urandom_range(0, b.size() - 2)];
          2: b = {b, rand_bytes($urandom_range(1, 3))};
          3: begin
            k = $urandom_range(0, b.size() - 1);
            b[k] = b[k] ^ (8'd1 << $urandom_range(0, 7));
          end
          default: ;
        endcase
        queue_run(b);
      end
    end
  endtask

  task automatic drain();
    while (pend_q.size() > 0 || exp_words.size() > 0) @(posedge clk);
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch at result %0d: %s got %0d expected %0d", words_out, what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    logic     nv;
    in_word_t w;
    if (rst_n) begin
      nv = in_tvalid;
      if (in_tvalid && in_tready) begin
        exp_words.push_back(predict_word(in_tdata, in_tlast));
        words_in++;
        void'(pend_q.pop_front());
        nv = 1'b0;
      end
      if (!nv && pend_q.size() > 0 && $urandom_range(0, 99) >= send_idle) nv = 1'b1;
      if (nv) begin
        w = pend_q[0];
        in_tdata <= w.data;
        in_tlast <= w.last;
      end
      in_tvalid <= nv;
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [7:0] want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (exp_words.size() == 0) begin
          report("unexpected word", out_tdata, 0);
        end else begin
          want = exp_words.pop_front();
          if (out_tdata[3:0] != want[3:0]) report("field_class", out_tdata[3:0], want[3:0]);
          if (out_tdata[4] != want[4]) report("field_end", out_tdata[4], want[4]);
          if (out_tdata[6:5] != want[6:5]) report("status", out_tdata[6:5], want[6:5]);
        end
        words_out++;
      end
      out_tready <= !hold && ($urandom_range(0, 99) >= rcv_stall);
    end
  end

  initial begin
    clear_tracker();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: header, length and integer corner cases, then clean certificates and a random batch
    queue_run('{8'h30, 8'h80});
    queue_run('{8'h30, 8'h81, 8'h05});
    queue_run('{8'h30, 8'h82, 8'h00, 8'h80});
    queue_run('{8'h30, 8'h85, 8'h01});
    queue_run('{8'h30, 8'h84, 8'hff, 8'hff, 8'hff, 8'hff, 8'h02});
    queue_run('{8'h30, 8'h03, 8'ha0, 8'h01, 8'h02});
    queue_run('{8'h30, 8'h04, 8'h02, 8'h02, 8'h00, 8'h01});
    queue_run('{8'h30, 8'h04, 8'h02, 8'h02, 8'hff, 8'h80});
    queue_run('{8'h30, 8'h02, 8'h02, 8'h00});
    queue_run('{8'hff});
    queue_run(tlv(TAG_SEQ, {tlv(TAG_A0, {8'h02, 8'h01, 8'h00, 8'h00}), 8'h00}));
    for (int i = 0; i < 2; i++) queue_run(make_cert());
    queue_random(120);
    drain();

    send_idle = 50;
    queue_random(120);
    fork
      begin
        hold <= 1'b1;
        repeat (300) @(posedge clk);
        hold <= 1'b0;
      end
    join_none
    drain();

    send_idle = 0;
    rcv_stall = 50;
    queue_random(120);
    drain();

    send_idle = 24;
    rcv_stall = 24;
    queue_random(120);
    drain();
    repeat (10) @(posedge clk);

    $display("covered %0d encodings, %0d bytes in, %0d result words out",
             certs, words_in, words_out);
    if (errors == 0 && exp_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout with %0d results pending", exp_words.size());
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ----- der_tbs_certificate_checker_unit.f -----
+incdir+rtl
rtl/dtc_pkg.sv
rtl/dtc_core.sv
rtl/der_tbs_certificate_checker_unit.sv
sim/tb_der_tbs_certificate_checker_unit.sv
